@@ sv/fraction_multiply_reduce_top_macros.svh @@
// Assertion helpers shared by the RTL files; every check samples on clk and
// is disabled while rst_n is low.
`ifndef FRACTION_MULTIPLY_REDUCE_TOP_MACROS_SVH
`define FRACTION_MULTIPLY_REDUCE_TOP_MACROS_SVH

// Same-cycle implication.
`define FMR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmr check failed");

// Next-cycle implication.
`define FMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmr check failed");

`endif

@@ sv/fmr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fmr_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int IN_BITS   = 4 * WORD_BITS;
    localparam int OUT_BITS  = 4 * WORD_BITS;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    // Two's complement magnitude; the most negative value maps to 2^(W-1).
    function automatic word_t magnitude(input word_t v);
        word_t r;
        r = v[WORD_BITS-1] ? (~v + word_t'(1)) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/fmr_divu.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "fraction_multiply_reduce_top_macros.svh"

// Unsigned restoring divider, one quotient bit per cycle.
module fmr_divu (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire fmr_pkg::word_t dividend,
    input  wire fmr_pkg::word_t divisor,
    output logic                done,
    output fmr_pkg::word_t      quotient
);

    logic            busy_reg;
    logic            done_reg;
    fmr_pkg::cnt_t   cnt_reg;
    fmr_pkg::word_t  rem_reg;
    fmr_pkg::word_t  quo_reg;
    fmr_pkg::word_t  div_reg;

    logic [fmr_pkg::WORD_BITS:0] shifted;
    logic [fmr_pkg::WORD_BITS:0] trial;
    logic                        fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[fmr_pkg::WORD_BITS-1]};
        trial   = shifted - {1'b0, div_reg};
        fits    = (shifted >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + fmr_pkg::cnt_t'(1);
                if (cnt_reg == fmr_pkg::cnt_t'(fmr_pkg::WORD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[fmr_pkg::WORD_BITS-1:0] : shifted[fmr_pkg::WORD_BITS-1:0];
            quo_reg <= {quo_reg[fmr_pkg::WORD_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `FMR_ASSERT_IMP(a_rem_below_div, busy_reg, rem_reg < div_reg)
    `FMR_ASSERT_NEXT(a_start_busy, start, busy_reg && cnt_reg == '0)
    `FMR_ASSERT_IMP(a_done_not_busy, done_reg, !busy_reg)

endmodule

`default_nettype wire

@@ sv/fraction_multiply_reduce_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "fraction_multiply_reduce_top_macros.svh"

// Fraction multiply and reduce.
// Input transfer on s_*: tdata holds num_a, den_a, num_b, den_b (32 bits each,
// lowest first). Output transfer on m_*: tdata holds prod_num, prod_den,
// red_num, red_den. Every input gives exactly one output.
// One item is in flight at a time; s_tready is high only while the sequencer
// is idle. An item passes the shared multiplier for the numerator and then
// the denominator product, forms magnitudes, runs a binary gcd of one shift,
// swap or subtract per cycle, then two passes of a restoring divider, each a
// start state and a wait for its done, which are skipped when the gcd is
// zero, and finally loads the output register.
// The output register holds a result until m_tready takes it; the next input
// is accepted meanwhile, but its result waits while the previous one is
// unread. Reset clears the sequencer and m_tvalid; no result is pending.
module fraction_multiply_reduce_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [fmr_pkg::IN_BITS-1:0]  s_tdata,  // num_a, den_a, num_b, den_b
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [fmr_pkg::OUT_BITS-1:0]      m_tdata   // prod_num, prod_den, red_num, red_den
);

    localparam int W = fmr_pkg::WORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_D,
        ST_MAG,
        ST_GCD,
        ST_DIV_N,
        ST_WAIT_N,
        ST_DIV_D,
        ST_WAIT_D,
        ST_FINISH
    } state_t;

    state_t         state_reg;
    logic [fmr_pkg::IN_BITS-1:0] in_reg;
    fmr_pkg::word_t pn_reg;
    fmr_pkg::word_t pd_reg;
    fmr_pkg::word_t x_reg;
    fmr_pkg::word_t y_reg;
    fmr_pkg::cnt_t  k_reg;
    fmr_pkg::word_t g_reg;
    fmr_pkg::word_t rn_reg;
    fmr_pkg::word_t rd_reg;
    logic           m_tvalid_reg;
    logic [fmr_pkg::OUT_BITS-1:0] m_tdata_reg;

    fmr_pkg::word_t mul_a;
    fmr_pkg::word_t mul_b;
    fmr_pkg::word_t mul_p;
    fmr_pkg::word_t mag_pn;
    fmr_pkg::word_t mag_pd;
    fmr_pkg::word_t div_dividend;
    fmr_pkg::word_t div_q;
    fmr_pkg::word_t signed_q;
    logic           div_start;
    logic           div_done;
    logic           out_load;

    // One multiplier shared by the numerator and denominator products.
    always_comb
    begin
        if (state_reg == ST_MUL_N)
        begin
            mul_a = in_reg[W-1:0];
            mul_b = in_reg[3*W-1:2*W];
        end
        else
        begin
            mul_a = in_reg[2*W-1:W];
            mul_b = in_reg[4*W-1:3*W];
        end
        mul_p = fmr_pkg::word_t'(mul_a * mul_b);
    end

    assign mag_pn       = fmr_pkg::magnitude(pn_reg);
    assign mag_pd       = fmr_pkg::magnitude(pd_reg);
    assign div_start    = (state_reg == ST_DIV_N) || (state_reg == ST_DIV_D);
    assign div_dividend = (state_reg == ST_DIV_N) ? mag_pn : mag_pd;
    // Load the output register once the previous result is gone or leaving.
    assign out_load     = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // Restore the sign of the part being divided.
    always_comb
    begin
        if (state_reg == ST_WAIT_N)
            signed_q = pn_reg[W-1] ? (~div_q + fmr_pkg::word_t'(1)) : div_q;
        else
            signed_q = pd_reg[W-1] ? (~div_q + fmr_pkg::word_t'(1)) : div_q;
    end

    fmr_divu u_divu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_MUL_N;
                end
                ST_MUL_N:  state_reg <= ST_MUL_D;
                ST_MUL_D:  state_reg <= ST_MAG;
                ST_MAG:    state_reg <= ST_GCD;
                ST_GCD:
                begin
                    if (y_reg == '0)
                    begin
                        if (x_reg == '0)
                            state_reg <= ST_FINISH;
                        else
                            state_reg <= ST_DIV_N;
                    end
                end
                ST_DIV_N:  state_reg <= ST_WAIT_N;
                ST_WAIT_N:
                begin
                    if (div_done)
                        state_reg <= ST_DIV_D;
                end
                ST_DIV_D:  state_reg <= ST_WAIT_D;
                ST_WAIT_D:
                begin
                    if (div_done)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // Hold until the previous result has been taken.
                    if (out_load)
                    begin
                        m_tdata_reg <= {rd_reg, rn_reg, pd_reg, pn_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    in_reg <= s_tdata;
            end
            ST_MUL_N: pn_reg <= mul_p;
            ST_MUL_D: pd_reg <= mul_p;
            ST_MAG:
            begin
                x_reg <= mag_pn;
                y_reg <= mag_pd;
                k_reg <= '0;
                rn_reg <= pn_reg;
                rd_reg <= pd_reg;
            end
            ST_GCD:
            begin
                // Binary gcd: one shift, swap or subtract per cycle.
                priority if (y_reg == '0)
                begin
                    g_reg <= x_reg << k_reg;
                end
                else if (x_reg == '0)
                begin
                    x_reg <= y_reg;
                    y_reg <= '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + fmr_pkg::cnt_t'(1);
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_reg <= y_reg >> 1;
                end
                else if (x_reg > y_reg)
                begin
                    x_reg <= y_reg;
                    y_reg <= x_reg;
                end
                else
                begin
                    y_reg <= y_reg - x_reg;
                end
            end
            ST_WAIT_N:
            begin
                if (div_done)
                    rn_reg <= signed_q;
            end
            ST_WAIT_D:
            begin
                if (div_done)
                    rd_reg <= signed_q;
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FMR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `FMR_ASSERT_IMP(a_div_nonzero, div_start, g_reg != '0)
    `FMR_ASSERT_IMP(a_zero_passes, m_tvalid && m_tdata[2*W-1:0] == '0,
                    m_tdata[4*W-1:2*W] == '0)

endmodule

`default_nettype wire

@@ bench/fraction_multiply_reduce_top_tb.sv @@
`timescale 1ns / 1ps

module fraction_multiply_reduce_top_tb;

    typedef fmr_pkg::word_t word_t;

    localparam int WORD_BITS    = fmr_pkg::WORD_BITS;
    localparam int IN_BITS      = fmr_pkg::IN_BITS;
    localparam int OUT_BITS     = fmr_pkg::OUT_BITS;
    localparam int N_RANDOM     = 1730;
    localparam int STALL_LIMIT  = 6000;
    localparam int TAIL_CYCLES  = 300;
    localparam int HOLD_CYCLES  = 1200;
    localparam int IDLE_PCT     = 19;
    localparam word_t MOST_NEG  = word_t'(32'h8000_0000);
    localparam word_t MOST_POS  = word_t'(32'h7FFF_FFFF);

    typedef enum
    {
        KIND_RAW,
        KIND_SCALED,
        KIND_SPECIAL,
        KIND_REDUCE,
        KIND_INTEGER,
        KIND_POW2
    } stim_kind_t;

    typedef struct
    {
        word_t num_a;
        word_t den_a;
        word_t num_b;
        word_t den_b;
        bit    drain;
    } frac_pair_t;

    typedef struct
    {
        word_t prod_num;
        word_t prod_den;
        word_t red_num;
        word_t red_den;
    } frac_prod_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    frac_pair_t pair_q[$];
    frac_prod_t prod_q[$];
    int         err_cnt = 0;
    logic       all_done = 1'b1;

    fraction_multiply_reduce_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic word_t abs_word(input word_t v);
        return v[WORD_BITS-1] ? word_t'(0) - v : v;
    endfunction

    function automatic word_t signed_quot(input word_t v, input word_t g);
        word_t q;
        q = abs_word(v) / g;
        return v[WORD_BITS-1] ? word_t'(0) - q : q;
    endfunction

    function automatic frac_prod_t multiply_reduce(input logic [IN_BITS-1:0] d);
        frac_prod_t p;
        word_t      x;
        word_t      y;
        word_t      r;
        p.prod_num = d[0*WORD_BITS +: WORD_BITS] * d[2*WORD_BITS +: WORD_BITS];
        p.prod_den = d[1*WORD_BITS +: WORD_BITS] * d[3*WORD_BITS +: WORD_BITS];
        x = abs_word(p.prod_num);
        y = abs_word(p.prod_den);
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        // gcd of zero means both parts are zero: pass the product through
        if (x == 0)
        begin
            p.red_num = p.prod_num;
            p.red_den = p.prod_den;
        end
        else
        begin
            p.red_num = signed_quot(p.prod_num, x);
            p.red_den = signed_quot(p.prod_den, x);
        end
        return p;
    endfunction

    function automatic word_t rand_special();
        int sh;
        sh = $urandom_range(0, WORD_BITS - 2);
        case ($urandom_range(0, 6))
            0: return word_t'(0);
            1: return word_t'(1);
            2: return word_t'(-1);
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return word_t'(1) << sh;
            default: return word_t'(0) - (word_t'(1) << sh);
        endcase
    endfunction

    function automatic word_t rand_small(input int hi);
        word_t v;
        v = word_t'($urandom_range(0, hi));
        return $urandom_range(0, 1) ? word_t'(0) - v : v;
    endfunction

    function automatic stim_kind_t pick_kind();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return KIND_RAW;
        else if (sel < 55)
            return KIND_SCALED;
        else if (sel < 65)
            return KIND_SPECIAL;
        else if (sel < 75)
            return KIND_REDUCE;
        else if (sel < 85)
            return KIND_INTEGER;
        return KIND_POW2;
    endfunction

    task automatic add_pair(input word_t na, input word_t da, input word_t nb,
                            input word_t db, input bit drain);
        frac_pair_t it;
        it.num_a = na;
        it.den_a = da;
        it.num_b = nb;
        it.den_b = db;
        it.drain = drain;
        pair_q.push_back(it);
    endtask

    task automatic add_random(input bit drain);
        stim_kind_t kind;
        word_t      k;
        int         sh;
        kind = pick_kind();
        k = word_t'($urandom_range(1, 5000));
        sh = $urandom_range(0, WORD_BITS - 1);
        case (kind)
            KIND_RAW:
                add_pair($urandom, $urandom, $urandom, $urandom, drain);
            KIND_SCALED:
                add_pair(rand_small(300) * k, rand_small(300) * k,
                         rand_small(300), rand_small(300), drain);
            KIND_SPECIAL:
                add_pair(rand_special(), rand_special(), rand_special(),
                         rand_special(), drain);
            KIND_REDUCE:
                add_pair($urandom, rand_small(100000) * k, word_t'(1), word_t'(1),
                         drain);
            KIND_INTEGER:
                add_pair(rand_small(1000), rand_small(1000), rand_small(100000),
                         word_t'(1), drain);
            default:
                add_pair(rand_small(7) << sh, rand_small(7) << (WORD_BITS - 1 - sh),
                         rand_small(3) << $urandom_range(0, 15),
                         rand_small(3) << $urandom_range(0, 15), drain);
        endcase
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
        err_cnt++;
    endtask

    // Sender: hold the offered item until its transfer, then maybe idle.
    int         sent_cnt = 0;
    logic       took;
    logic       offer;
    frac_pair_t head;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            took = s_tvalid && s_tready;
            if (took)
                sent_cnt++;
            if (s_tvalid && !took)
                offer = 1'b1;
            else if (pair_q.size() == 0)
                offer = 1'b0;
            else if (pair_q[0].drain && (took || !all_done))
                offer = 1'b0;
            else if ((sent_cnt < 600 || sent_cnt >= 900)
                     && $urandom_range(0, 99) < IDLE_PCT)
                offer = 1'b0;
            else
            begin
                offer = 1'b1;
                head = pair_q.pop_front();
                s_tdata <= {head.den_b, head.num_b, head.den_a, head.num_a};
            end
            s_tvalid <= offer;
        end
    end

    // Receiver readiness, with one long hold-off early on.
    int   rd_cnt = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rd_cnt++;
            if (!hold_done && rd_cnt == 30)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rd_cnt >= 300 && rd_cnt < 500)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Checker: compare each result transfer against the oldest expectation.
    frac_prod_t want;
    frac_prod_t got;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (prod_q.size() == 0)
                begin
                    $display("unexpected result transfer");
                    err_cnt++;
                end
                else
                begin
                    want = prod_q.pop_front();
                    got.prod_num = m_tdata[0*WORD_BITS +: WORD_BITS];
                    got.prod_den = m_tdata[1*WORD_BITS +: WORD_BITS];
                    got.red_num  = m_tdata[2*WORD_BITS +: WORD_BITS];
                    got.red_den  = m_tdata[3*WORD_BITS +: WORD_BITS];
                    if (got.prod_num !== want.prod_num)
                        report_mismatch("prod_num", got.prod_num, want.prod_num);
                    if (got.prod_den !== want.prod_den)
                        report_mismatch("prod_den", got.prod_den, want.prod_den);
                    if (got.red_num !== want.red_num)
                        report_mismatch("red_num", got.red_num, want.red_num);
                    if (got.red_den !== want.red_den)
                        report_mismatch("red_den", got.red_den, want.red_den);
                end
            end
            if (s_tvalid && s_tready)
                prod_q.push_back(multiply_reduce(s_tdata));
            all_done <= (prod_q.size() == 0);
        end
    end

    int stall_cnt = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        // unit, zero, sign, most-negative and most-positive corners, and reducible pairs
        add_pair(1, 1, 1, 1, 1'b0);
        add_pair(0, 5, 3, 7, 1'b0);
        add_pair(0, 0, 0, 0, 1'b0);
        add_pair(6, 4, 1, 1, 1'b0);
        add_pair(2, 3, 5, 1, 1'b0);
        add_pair(word_t'(-4), 6, 3, word_t'(-2), 1'b0);
        add_pair(MOST_NEG, 1, 1, 1, 1'b0);
        add_pair(MOST_NEG, MOST_NEG, 1, 1, 1'b0);
        add_pair(MOST_NEG, 2, 1, 1, 1'b0);
        add_pair(5, 0, 1, 1, 1'b0);
        add_pair(word_t'(-7), 0, 1, 1, 1'b0);
        add_pair(0, MOST_NEG, 1, 1, 1'b0);
        add_pair(MOST_POS, MOST_POS, 1, 1, 1'b0);
        add_pair(MOST_POS, 1, MOST_POS, 1, 1'b0);
        add_pair(65536, 3, 65536, 5, 1'b0);
        add_pair(MOST_NEG, 1, word_t'(-1), 1, 1'b0);
        add_pair(word_t'(-1), word_t'(-1), word_t'(-1), word_t'(-1), 1'b0);
        add_pair(MOST_POS, MOST_NEG, 1, 1, 1'b0);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        add_pair(12, 18, 35, 14, 1'b0);
        add_pair(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 1'b0);
        add_pair(32'h4000_0000, 3, 2, 1, 1'b0);
        add_pair(word_t'(-3), word_t'(-9), 1, 1, 1'b0);
        for (int i = 0; i < N_RANDOM; i++)
            add_random(i == 1000 || i == 1400);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!(pair_q.size() == 0 && !s_tvalid && all_done));
        repeat (TAIL_CYCLES) @(negedge clk);

        if (prod_q.size() != 0)
        begin
            $display("%0d results never arrived", prod_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/fmr_pkg.sv
sv/fmr_divu.sv
sv/fraction_multiply_reduce_top.sv
bench/fraction_multiply_reduce_top_tb.sv
